### design/aupc_pkg.sv
// Package for the ARGB unpremultiply converter.
// Holds shared constants, the queue item type and the divider stage types.
// No dependencies.
package aupc_pkg;

	localparam int ChanCnt      = 3;
	localparam int ByteW        = 8;
	localparam int NumWidth     = 16;
	localparam int BitsPerStage = 2;
	localparam int DivStages    = NumWidth / BitsPerStage;
	localparam int QueueDepth   = 4;
	localparam int QueuePtrW    = $clog2(QueueDepth);
	localparam int AlphaLsb     = 24;

	localparam logic [2:0] ChanRgba = 3'd4;
	localparam logic [2:0] ChanRgb  = 3'd3;

	// Classified pixel as it sits in the queue
	typedef struct packed {
		logic                              keep;
		logic                              zero_alpha;
		logic [ByteW-1:0]                  alpha;
		logic [ChanCnt-1:0][ByteW-1:0]     color;
		logic [ChanCnt-1:0][NumWidth-1:0]  num;
		logic                              row_end;
		logic                              frame_end;
	} work_t;

	// Running state of one color divider
	typedef struct packed {
		logic [ByteW-1:0]    rem;
		logic [NumWidth-1:0] num;
		logic [ByteW-1:0]    quo;
	} chan_t;

	// One divider pipeline stage
	typedef struct packed {
		logic [ChanCnt-1:0][$bits(chan_t)-1:0] ch;
		logic                                  keep;
		logic                                  zero_alpha;
		logic [ByteW-1:0]                      alpha;
		logic [ChanCnt-1:0][ByteW-1:0]         color;
		logic                                  row_end;
		logic                                  frame_end;
	} stage_t;

endpackage

### design/aupc_if.sv
// Stream interfaces for the ARGB unpremultiply converter.
// pix_in_if carries source pixels, pix_out_if carries converted pixels.
// No dependencies.
interface pix_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_word;
	logic        row_end;
	logic        frame_end;

	modport source (output valid, output pixel_word, output row_end, output frame_end,
		input ready);
	modport sink (input valid, input pixel_word, input row_end, input frame_end,
		output ready);
endinterface

interface pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha_out;
	logic [2:0] channel_count;
	logic       row_end_out;
	logic       frame_end_out;

	modport source (output valid, output red, output green, output blue, output alpha_out,
		output channel_count, output row_end_out, output frame_end_out, input ready);
	modport sink (input valid, input red, input green, input blue, input alpha_out,
		input channel_count, input row_end_out, input frame_end_out, output ready);
endinterface

### design/argb_unpremultiply_convert_top.sv
// Top level of the ARGB unpremultiply converter: front end, queue, divider back end.
// Depends on aupc_pkg, pix_in_if, pix_out_if, aupc_front, aupc_queue, aupc_back.
//
//  channel   dir  payload                                          handshake
//  src       in   pixel_word[31:0], row_end, frame_end              valid/ready
//  dst       out  red, green, blue, alpha_out, channel_count,       valid/ready
//                 row_end_out, frame_end_out
//  cfg       in   cfg_wdata (keep_alpha)                            cfg_we
//
// One pixel per cycle sustained while dst is ready; the front register loads at the src
// transfer, then the queue, eight divider stages and output register lead to dst valid.
// The divider resolves two quotient bits per stage over a 16-bit numerator.
// Reset empties the queue and pipeline and sets keep_alpha to 1.
// A dst stall freezes the divider pipeline; the 4-entry queue and the front register
// take up to five more src transfers before src stalls.
module argb_unpremultiply_convert_top (
	input  logic     clk,
	input  logic     arst_n,
	pix_in_if.sink   src,
	pix_out_if.source dst,
	input  logic     cfg_we,
	input  logic     cfg_wdata
);
	import aupc_pkg::*;

	logic  keep_alpha_q;
	logic  push_valid;
	logic  push_ready;
	work_t push_data;
	logic  head_valid;
	logic  head_pop;
	work_t head_data;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_alpha_q <= 1'b1;
		end else if (cfg_we) begin
			keep_alpha_q <= cfg_wdata;
		end
	end

	aupc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src),
		.keep_alpha (keep_alpha_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	aupc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (head_valid),
		.pop_ready  (head_pop),
		.pop_data   (head_data)
	);

	aupc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head_data  (head_data),
		.dst        (dst)
	);

endmodule

### design/aupc_front.sv
// Front end: accepts source pixels, splits fields and forms divider numerators.
// Depends on aupc_pkg and pix_in_if.
module aupc_front (
	input  logic           clk,
	input  logic           arst_n,
	pix_in_if.sink         src,
	input  logic           keep_alpha,
	output logic           push_valid,
	input  logic           push_ready,
	output aupc_pkg::work_t push_data
);
	import aupc_pkg::*;

	logic  v_s1;
	work_t item_s1;
	work_t item_d;
	logic  take;

	assign src.ready = !v_s1 || push_ready;
	assign take      = src.valid && src.ready;

	// Split the word and build c*255 + alpha/2 for each color
	always_comb begin
		item_d            = '0;
		item_d.keep       = keep_alpha;
		item_d.alpha      = src.pixel_word[AlphaLsb +: ByteW];
		item_d.zero_alpha = (item_d.alpha == '0);
		item_d.row_end    = src.row_end;
		item_d.frame_end  = src.frame_end;
		for (int i = 0; i < ChanCnt; i++) begin
			// channel 0 red, 1 green, 2 blue
			item_d.color[i] = src.pixel_word[(ChanCnt-1-i)*ByteW +: ByteW];
			item_d.num[i]   = {item_d.color[i], 8'd0} - {8'd0, item_d.color[i]}
				+ {9'd0, item_d.alpha[ByteW-1:1]};
		end
	end

	// Hold the classified item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (src.ready) begin
			v_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

	assign push_valid = v_s1;
	assign push_data  = item_s1;

endmodule

### design/aupc_queue.sv
// Short queue that decouples the front end from the divider pipeline.
// Depends on aupc_pkg.
module aupc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  aupc_pkg::work_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output aupc_pkg::work_t pop_data
);
	import aupc_pkg::*;

	work_t                mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueuePtrW:0]   count_q;
	logic                 push;
	logic                 pop;

	assign push_ready = (count_q != QueueDepth[QueuePtrW:0]);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### design/aupc_back.sv
// Back end: pipelined restoring divider, two quotient bits per stage, plus
// the output register. Depends on aupc_pkg and pix_out_if.
module aupc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	output logic            head_pop,
	input  aupc_pkg::work_t head_data,
	pix_out_if.source       dst
);
	import aupc_pkg::*;

	// Two restoring steps; remainder stays below alpha
	function automatic chan_t div_step2(chan_t c, logic [ByteW-1:0] a);
		chan_t          r;
		logic [ByteW:0] t;
		r = c;
		for (int j = 0; j < BitsPerStage; j++) begin
			t     = {r.rem, r.num[NumWidth-1]};
			r.num = {r.num[NumWidth-2:0], 1'b0};
			if (t >= {1'b0, a}) begin
				r.rem = ByteW'(t - {1'b0, a});
				r.quo = {r.quo[ByteW-2:0], 1'b1};
			end else begin
				r.rem = t[ByteW-1:0];
				r.quo = {r.quo[ByteW-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	stage_t               div_s [DivStages];
	logic [DivStages-1:0] v_s;
	stage_t               step_in [DivStages];
	stage_t               step_out [DivStages];
	logic                 out_v_q;
	logic                 en;
	stage_t               last;
	chan_t                lc;

	// Whole pipeline advances when the output register is free
	assign en       = !out_v_q || dst.ready;
	assign head_pop = en && head_valid;

	// Load the queue head as the first divider input
	always_comb begin
		chan_t c0;
		step_in[0]            = '0;
		step_in[0].keep       = head_data.keep;
		step_in[0].zero_alpha = head_data.zero_alpha;
		step_in[0].alpha      = head_data.alpha;
		step_in[0].color      = head_data.color;
		step_in[0].row_end    = head_data.row_end;
		step_in[0].frame_end  = head_data.frame_end;
		for (int i = 0; i < ChanCnt; i++) begin
			c0               = '0;
			c0.num           = head_data.num[i];
			step_in[0].ch[i] = c0;
		end
		for (int k = 1; k < DivStages; k++) begin
			step_in[k] = div_s[k-1];
		end
	end

	// Each stage advances every color divider by div_step2
	always_comb begin
		for (int k = 0; k < DivStages; k++) begin
			step_out[k] = step_in[k];
			for (int i = 0; i < ChanCnt; i++) begin
				step_out[k].ch[i] = div_step2(chan_t'(step_in[k].ch[i]), step_in[k].alpha);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s     <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s     <= {v_s[DivStages-2:0], head_valid};
			out_v_q <= v_s[DivStages-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DivStages; k++) begin
				div_s[k] <= step_out[k];
			end
		end
	end

	// Format the result: quotient, zero for clear pixels, or raw color
	assign last = div_s[DivStages-1];

	logic [ChanCnt-1:0][ByteW-1:0] res_d;
	always_comb begin
		for (int i = 0; i < ChanCnt; i++) begin
			lc = chan_t'(last.ch[i]);
			if (!last.keep) begin
				res_d[i] = last.color[i];
			end else if (last.zero_alpha) begin
				res_d[i] = '0;
			end else begin
				res_d[i] = lc.quo;
			end
		end
	end

	logic [ChanCnt-1:0][ByteW-1:0] res_q;
	logic [ByteW-1:0]              alpha_q;
	logic [2:0]                    count_q;
	logic                          row_end_q;
	logic                          frame_end_q;

	// Hold the result until the sink takes the transfer
	always_ff @(posedge clk) begin
		if (en) begin
			res_q       <= res_d;
			alpha_q     <= last.keep ? last.alpha : '0;
			count_q     <= last.keep ? ChanRgba : ChanRgb;
			row_end_q   <= last.row_end;
			frame_end_q <= last.frame_end;
		end
	end

	assign dst.valid         = out_v_q;
	assign dst.red           = res_q[0];
	assign dst.green         = res_q[1];
	assign dst.blue          = res_q[2];
	assign dst.alpha_out     = alpha_q;
	assign dst.channel_count = count_q;
	assign dst.row_end_out   = row_end_q;
	assign dst.frame_end_out = frame_end_q;

endmodule

### bench/tb_argb_unpremultiply_convert_top.sv
// Self-checking bench for the ARGB unpremultiply converter: directed pixel table,
// then random pixel streams in both alpha modes with random stalls on both channels.
// Depends on aupc_pkg, pix_in_if, pix_out_if and argb_unpremultiply_convert_top.
module tb_argb_unpremultiply_convert_top;
	import aupc_pkg::*;

	localparam int StallLimit = 2000;
	localparam int TailCycles = 24;
	localparam int LongHold   = 120;

	// One converted pixel as seen on the output channel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [2:0] chans;
		logic       row_end;
		logic       frame_end;
	} pix_result_t;

	// One directed stimulus row; typed rows carry their own result
	typedef struct packed {
		logic        keep;
		logic [31:0] word;
		logic        row_end;
		logic        frame_end;
		logic        typed;
		pix_result_t res;
	} pix_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic cfg_wdata;

	pix_in_if  src_if();
	pix_out_if dst_if();

	pix_result_t pending_q[$];
	logic        keep_alpha_model;
	int          fail_cnt;
	int          idle_cycles;
	bit          src_idle_en;
	bit          dst_idle_en;
	bit          pressure_armed;

	pix_row_t dir_rows [19] = '{
		'{1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b1,
			'{8'h00, 8'h00, 8'h00, 8'h00, ChanRgba, 1'b0, 1'b0}},
		'{1'b1, 32'h00FF_FFFF, 1'b1, 1'b0, 1'b1,
			'{8'h00, 8'h00, 8'h00, 8'h00, ChanRgba, 1'b1, 1'b0}},
		'{1'b1, 32'hFF12_3456, 1'b0, 1'b0, 1'b1,
			'{8'h12, 8'h34, 8'h56, 8'hFF, ChanRgba, 1'b0, 1'b0}},
		'{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
			'{8'hFF, 8'hFF, 8'hFF, 8'hFF, ChanRgba, 1'b1, 1'b1}},
		'{1'b1, 32'hFF00_0000, 1'b0, 1'b1, 1'b1,
			'{8'h00, 8'h00, 8'h00, 8'hFF, ChanRgba, 1'b0, 1'b1}},
		'{1'b1, 32'h8040_2010, 1'b0, 1'b0, 1'b0, '0},
		'{1'b1, 32'h01FF_FFFF, 1'b1, 1'b0, 1'b0, '0},
		'{1'b1, 32'h0101_0101, 1'b0, 1'b0, 1'b0, '0},
		'{1'b1, 32'h7F7F_7F7F, 1'b0, 1'b0, 1'b0, '0},
		'{1'b1, 32'h02FF_00FF, 1'b0, 1'b1, 1'b0, '0},
		'{1'b1, 32'hFEFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
		'{1'b1, 32'h55AA_55AA, 1'b1, 1'b1, 1'b0, '0},
		'{1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b1,
			'{8'h00, 8'h00, 8'h00, 8'h00, ChanRgb, 1'b0, 1'b0}},
		'{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
			'{8'hFF, 8'hFF, 8'hFF, 8'h00, ChanRgb, 1'b1, 1'b1}},
		'{1'b0, 32'h1234_5678, 1'b0, 1'b0, 1'b1,
			'{8'h34, 8'h56, 8'h78, 8'h00, ChanRgb, 1'b0, 1'b0}},
		'{1'b0, 32'h00AB_CDEF, 1'b0, 1'b1, 1'b1,
			'{8'hAB, 8'hCD, 8'hEF, 8'h00, ChanRgb, 1'b0, 1'b1}},
		'{1'b0, 32'hAA55_AA55, 1'b0, 1'b0, 1'b0, '0},
		'{1'b1, 32'h1020_3040, 1'b0, 1'b0, 1'b0, '0},
		'{1'b1, 32'h00FF_FFFF, 1'b1, 1'b1, 1'b1,
			'{8'h00, 8'h00, 8'h00, 8'h00, ChanRgba, 1'b1, 1'b1}}
	};

	argb_unpremultiply_convert_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.src      (src_if),
		.dst      (dst_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Convert one premultiplied pixel to straight alpha, or strip alpha in opaque mode
	function automatic pix_result_t unpremultiply_pixel(input logic [31:0] word,
			input logic row_end, input logic frame_end, input logic keep);
		pix_result_t r;
		logic [7:0]  a;
		logic [7:0]  c [3];
		logic [7:0]  q [3];
		int unsigned scaled;
		a    = word[31:24];
		c[0] = word[23:16];
		c[1] = word[15:8];
		c[2] = word[7:0];
		for (int i = 0; i < 3; i++) begin
			if (!keep) begin
				q[i] = c[i];
			end else if (a == 8'h00) begin
				q[i] = 8'h00;
			end else begin
				// keep only the low byte of the quotient, no saturation
				scaled = c[i] * 255 + a / 2;
				q[i]   = 8'(scaled / a);
			end
		end
		r.red       = q[0];
		r.green     = q[1];
		r.blue      = q[2];
		r.alpha     = keep ? a : 8'h00;
		r.chans     = keep ? ChanRgba : ChanRgb;
		r.row_end   = row_end;
		r.frame_end = frame_end;
		return r;
	endfunction

	// Well-formed premultiplied pixels half the time, plus zero alpha, opaque and raw words
	function automatic logic [31:0] random_pixel();
		logic [31:0] w;
		logic [7:0]  a;
		w = $urandom();
		case ($urandom_range(0, 9))
			0: w[31:24] = 8'h00;
			1: w[31:24] = 8'hFF;
			2, 3, 4, 5, 6: begin
				a        = 8'($urandom_range(1, 255));
				w[31:24] = a;
				w[23:16] = 8'($urandom_range(0, a));
				w[15:8]  = 8'($urandom_range(0, a));
				w[7:0]   = 8'($urandom_range(0, a));
			end
			default: ;
		endcase
		return w;
	endfunction

	// Offer one pixel, hold it until the transfer, then record its result
	task automatic send_pixel(input logic [31:0] word, input logic row_end,
			input logic frame_end, input pix_result_t want);
		int gap;
		if (src_idle_en && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			src_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_if.valid      <= 1'b1;
		src_if.pixel_word <= word;
		src_if.row_end    <= row_end;
		src_if.frame_end  <= frame_end;
		@(posedge clk);
		while (!src_if.ready) @(posedge clk);
		pending_q.push_back(want);
	endtask

	// Stop offering, drain the pipeline, then write keep_alpha
	task automatic set_keep_alpha(input logic value);
		src_if.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we           <= 1'b0;
		keep_alpha_model = value;
	endtask

	// Stimulus: reset, directed table, then random phases alternating the mode
	initial begin
		logic [31:0] word;
		logic        re;
		logic        fe;
		int          len;
		src_if.valid      <= 1'b0;
		src_if.pixel_word <= '0;
		src_if.row_end    <= 1'b0;
		src_if.frame_end  <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= 1'b1;
		keep_alpha_model  = 1'b1;
		src_idle_en       = 1'b1;
		dst_idle_en       = 1'b1;
		pressure_armed    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].keep != keep_alpha_model)
				set_keep_alpha(dir_rows[i].keep);
			send_pixel(dir_rows[i].word, dir_rows[i].row_end, dir_rows[i].frame_end,
				dir_rows[i].typed ? dir_rows[i].res :
				unpremultiply_pixel(dir_rows[i].word, dir_rows[i].row_end,
					dir_rows[i].frame_end, keep_alpha_model));
		end

		for (int p = 0; p < 5; p++) begin
			set_keep_alpha(p % 2 == 0);
			len            = (p == 0 || p == 2) ? 520 : (p == 1) ? 380 : 255;
			pressure_armed = (p == 0);
			// run the last phase at full rate on both sides
			src_idle_en    = (p != 4);
			dst_idle_en    = (p != 4);
			for (int n = 0; n < len; n++) begin
				word = random_pixel();
				re   = ($urandom_range(0, 7) == 0);
				fe   = ($urandom_range(0, 31) == 0);
				send_pixel(word, re, fe, unpremultiply_pixel(word, re, fe, keep_alpha_model));
			end
		end

		src_if.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (fail_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off to fill the block
	initial begin
		int  hold;
		bit  long_done;
		hold      = 0;
		long_done = 1'b0;
		dst_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold != 0) begin
				hold--;
				dst_if.ready <= (hold == 0);
			end else if (pressure_armed && !long_done) begin
				long_done = 1'b1;
				hold      = LongHold;
				dst_if.ready <= 1'b0;
			end else if (dst_idle_en && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 19);
				dst_if.ready <= 1'b0;
			end else begin
				dst_if.ready <= 1'b1;
			end
		end
	end

	// Compare each output transfer with the oldest pending result
	always @(posedge clk) begin
		pix_result_t got;
		pix_result_t want;
		if (arst_n && dst_if.valid && dst_if.ready) begin
			got = '{dst_if.red, dst_if.green, dst_if.blue, dst_if.alpha_out,
				dst_if.channel_count, dst_if.row_end_out, dst_if.frame_end_out};
			if (pending_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected pixel: r=%h g=%h b=%h a=%h ch=%0d re=%b fe=%b",
						got.red, got.green, got.blue, got.alpha, got.chans,
						got.row_end, got.frame_end);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					fail_cnt++;
					if (fail_cnt <= 10) begin
						$display("pixel mismatch: expected r=%h g=%h b=%h a=%h ch=%0d re=%b fe=%b",
							want.red, want.green, want.blue, want.alpha, want.chans,
							want.row_end, want.frame_end);
						$display("                got      r=%h g=%h b=%h a=%h ch=%0d re=%b fe=%b",
							got.red, got.green, got.blue, got.alpha, got.chans,
							got.row_end, got.frame_end);
					end
				end
			end
		end
	end

	// Watchdog: end the run when no transfer happens on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule

### argb_unpremultiply_convert_top.f
design/aupc_pkg.sv
design/aupc_if.sv
design/aupc_front.sv
design/aupc_queue.sv
design/aupc_back.sv
design/argb_unpremultiply_convert_top.sv
bench/tb_argb_unpremultiply_convert_top.sv
